### hw/rtl/rrt_pkg.sv
// Shared types and constants for the range reference-count table.
`timescale 1ns / 1ps
package rrt_pkg;
   localparam int TABLE_ENTRIES_DEF = 16;
   localparam int ADDR_BITS_DEF     = 32;
   localparam int COUNT_BITS_DEF    = 16;
   localparam int LEN_BITS          = 32;

   localparam logic FUNC_ENABLE  = 1'b0;
   localparam logic FUNC_DISABLE = 1'b1;

   typedef struct packed {
      logic        func;
      logic [31:0] address;
      logic [31:0] length;
   } req_type;

   typedef struct packed {
      logic active;
      logic miss_error;
      logic table_full;
   } rsp_type;
endpackage

### hw/rtl/range_refcount_table_top.sv
// Top level: first-range slot, handshake and result register around the table walker.
// Result: a first-slot item is registered, decided in S_DECIDE and answered from the result
// register; a table item waits in S_TABLE for the one-entry-a-cycle scan, merge and shift
// of the table.
// Items are taken one at a time; req_ready is low while an item is in work.
// Reset: synchronous, clears the first slot and the table fill count.
`timescale 1ns / 1ps
module range_refcount_table_top #(
   parameter int TABLE_ENTRIES = rrt_pkg::TABLE_ENTRIES_DEF,
   parameter int ADDR_BITS     = rrt_pkg::ADDR_BITS_DEF,
   parameter int COUNT_BITS    = rrt_pkg::COUNT_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rrt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rrt_pkg::rsp_type rsp_data
);
   typedef enum logic [1:0] {S_IDLE, S_DECIDE, S_TABLE, S_OUT} state_type;

   localparam logic [COUNT_BITS-1:0] CMAX = '1;
   localparam int OW = ((ADDR_BITS > rrt_pkg::LEN_BITS) ? ADDR_BITS : rrt_pkg::LEN_BITS) + 1;

   state_type             state_ff;
   rrt_pkg::req_type      req_ff;
   logic [ADDR_BITS-1:0]  fst_ff;
   logic [31:0]           fln_ff;
   logic [COUNT_BITS-1:0] fct_ff;
   rrt_pkg::rsp_type      rsp_ff;
   logic                  tstart_ff;

   logic [ADDR_BITS-1:0]  a;
   logic                  fhit, fnew, tdone, tmiss, tfull, tne;

   assign a = ADDR_BITS'(req_ff.address);
   assign fhit = (fct_ff != '0) && (a >= fst_ff) &&
                 ((OW'(a) - OW'(fst_ff)) < OW'(fln_ff));
   assign fnew = (req_ff.func == rrt_pkg::FUNC_ENABLE) && (fct_ff == '0) && !tne;

   rrt_table #(
      .TABLE_ENTRIES(TABLE_ENTRIES), .ADDR_BITS(ADDR_BITS), .COUNT_BITS(COUNT_BITS)
   ) u_table (
      .clock(clock), .reset(reset), .start(tstart_ff),
      .func(req_ff.func), .addr(a), .len(req_ff.length),
      .done(tdone), .miss(tmiss), .full(tfull), .nonempty(tne)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_data  = rsp_ff;

   // Handle first slot directly, hand everything else to the table.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fst_ff <= '0; fln_ff <= '0; fct_ff <= '0;
         tstart_ff <= 1'b0;
      end else begin
         tstart_ff <= (state_ff == S_DECIDE) && !fhit && !fnew;
         unique case (state_ff)
            S_IDLE: if (req_valid) begin
               req_ff <= req_data;
               state_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               if (fhit) begin
                  if (req_ff.func == rrt_pkg::FUNC_ENABLE) begin
                     if (fct_ff != CMAX) fct_ff <= fct_ff + 1'b1;
                     rsp_ff <= '{active: 1'b1, miss_error: 1'b0, table_full: 1'b0};
                  end else begin
                     fct_ff <= fct_ff - 1'b1;
                     if (fct_ff == COUNT_BITS'(1)) begin
                        fst_ff <= '0; fln_ff <= '0;
                     end
                     rsp_ff <= '{active: (fct_ff != COUNT_BITS'(1)) || tne,
                                 miss_error: 1'b0, table_full: 1'b0};
                  end
                  state_ff <= S_OUT;
               end else if (fnew) begin
                  fst_ff <= a; fln_ff <= req_ff.length; fct_ff <= COUNT_BITS'(1);
                  rsp_ff <= '{active: 1'b1, miss_error: 1'b0, table_full: 1'b0};
                  state_ff <= S_OUT;
               end else begin
                  state_ff <= S_TABLE;
               end
            end
            S_TABLE: if (tdone) begin
               rsp_ff <= '{active: (fct_ff != '0) || tne, miss_error: tmiss,
                           table_full: tfull};
               state_ff <= S_OUT;
            end
            S_OUT: if (rsp_ready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

### hw/rtl/rrt_table.sv
// Sorted range table with a sequencer that scans, shifts and merges one entry a cycle.
`timescale 1ns / 1ps
module rrt_table #(
   parameter int TABLE_ENTRIES = rrt_pkg::TABLE_ENTRIES_DEF,
   parameter int ADDR_BITS     = rrt_pkg::ADDR_BITS_DEF,
   parameter int COUNT_BITS    = rrt_pkg::COUNT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  func,
   input  logic [ADDR_BITS-1:0]  addr,
   input  logic [31:0]           len,
   output logic                  done,
   output logic                  miss,
   output logic                  full,
   output logic                  nonempty
);
   localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int NW = $clog2(TABLE_ENTRIES + 1);
   localparam int OW = ((ADDR_BITS > rrt_pkg::LEN_BITS) ? ADDR_BITS : rrt_pkg::LEN_BITS) + 1;
   localparam logic [COUNT_BITS-1:0] CMAX = '1;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_MERGE, S_SHIFT_UP, S_SHIFT_DN, S_FINISH
   } state_type;

   logic [ADDR_BITS-1:0]  st_mem [TABLE_ENTRIES];
   logic [31:0]           ln_mem [TABLE_ENTRIES];
   logic [COUNT_BITS-1:0] ct_mem [TABLE_ENTRIES];

   state_type             state_ff;
   logic [NW-1:0]         n_ff, i_ff, p_ff, k_ff;
   logic                  pvalid_ff, func_ff, miss_ff, full_ff, done_ff;
   logic [ADDR_BITS-1:0]  a_ff;
   logic [31:0]           len_ff, nlen_ff;
   logic [COUNT_BITS-1:0] cnt_ff;

   // Shared unit: one entry read, one containment / offset compare.
   logic [IW-1:0]         ri;
   logic [ADDR_BITS-1:0]  e_st;
   logic [31:0]           e_ln;
   logic [COUNT_BITS-1:0] e_ct;
   logic [OW-1:0]         off;
   logic [OW-1:0]         offl;
   logic [OW-1:0]         lmax;
   logic [31:0]           offsat;
   logic                  in_rng;
   logic [COUNT_BITS:0]   csum;

   assign ri   = i_ff[IW-1:0];
   assign e_st = st_mem[ri];
   assign e_ln = ln_mem[ri];
   assign e_ct = ct_mem[ri];
   assign off  = OW'(e_st) - OW'(a_ff);
   assign in_rng = (off == '0) || (off < OW'(len_ff));
   assign offl = off + OW'(e_ln);
   assign lmax = OW'({rrt_pkg::LEN_BITS{1'b1}});
   assign offsat = (offl > lmax) ? 32'hFFFF_FFFF : offl[31:0];
   assign csum = {1'b0, cnt_ff} + {1'b0, e_ct};

   assign done = done_ff;
   assign miss = miss_ff;
   assign full = full_ff;
   assign nonempty = (n_ff != '0);

   // Hold table and sequence the walk.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         n_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= (state_ff == S_FINISH);
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  a_ff <= addr; len_ff <= len; func_ff <= func;
                  i_ff <= '0; pvalid_ff <= 1'b0; p_ff <= '0;
                  miss_ff <= 1'b0; full_ff <= 1'b0;
                  state_ff <= S_SCAN;
               end
            end
            // Find predecessor: last entry with start <= address.
            S_SCAN: begin
               if (i_ff < n_ff && e_st <= a_ff) begin
                  p_ff <= i_ff; pvalid_ff <= 1'b1;
                  i_ff <= i_ff + 1'b1;
               end else begin
                  if (pvalid_ff && (OW'(a_ff) - OW'(st_mem[p_ff[IW-1:0]])) <
                      OW'(ln_mem[p_ff[IW-1:0]])) begin
                     // Hit: bump the count and widen the length, or decrement it and drop the entry at zero.
                     if (func_ff == rrt_pkg::FUNC_ENABLE) begin
                        if (ct_mem[p_ff[IW-1:0]] != CMAX)
                           ct_mem[p_ff[IW-1:0]] <= ct_mem[p_ff[IW-1:0]] + 1'b1;
                        if (ln_mem[p_ff[IW-1:0]] < len_ff)
                           ln_mem[p_ff[IW-1:0]] <= len_ff;
                        state_ff <= S_FINISH;
                     end else if (ct_mem[p_ff[IW-1:0]] == COUNT_BITS'(1)) begin
                        k_ff <= NW'(1);
                        state_ff <= S_SHIFT_DN;
                     end else begin
                        ct_mem[p_ff[IW-1:0]] <= ct_mem[p_ff[IW-1:0]] - 1'b1;
                        state_ff <= S_FINISH;
                     end
                  end else if (func_ff == rrt_pkg::FUNC_DISABLE) begin
                     miss_ff <= 1'b1;
                     state_ff <= S_FINISH;
                  end else begin
                     // Insert position: first entry with start >= address.
                     p_ff <= pvalid_ff ? ((st_mem[p_ff[IW-1:0]] < a_ff) ? p_ff + 1'b1 : p_ff)
                                       : '0;
                     i_ff <= pvalid_ff ? ((st_mem[p_ff[IW-1:0]] < a_ff) ? p_ff + 1'b1 : p_ff)
                                       : '0;
                     cnt_ff <= COUNT_BITS'(1);
                     nlen_ff <= len_ff;
                     k_ff <= '0;
                     state_ff <= S_MERGE;
                  end
               end
            end
            // Absorb following entries that start inside the new range.
            S_MERGE: begin
               if (i_ff < n_ff && in_rng) begin
                  cnt_ff <= csum[COUNT_BITS] ? CMAX : csum[COUNT_BITS-1:0];
                  if (offsat > nlen_ff) nlen_ff <= offsat;
                  k_ff <= k_ff + 1'b1;
                  i_ff <= i_ff + 1'b1;
               end else if (k_ff == '0) begin
                  if (n_ff >= NW'(TABLE_ENTRIES)) begin
                     full_ff <= 1'b1;
                     state_ff <= S_FINISH;
                  end else begin
                     i_ff <= n_ff;
                     state_ff <= S_SHIFT_UP;
                  end
               end else begin
                  st_mem[p_ff[IW-1:0]] <= a_ff;
                  ln_mem[p_ff[IW-1:0]] <= nlen_ff;
                  ct_mem[p_ff[IW-1:0]] <= cnt_ff;
                  p_ff <= p_ff + 1'b1;
                  k_ff <= k_ff - 1'b1;
                  if (k_ff == NW'(1)) state_ff <= S_FINISH;
                  else state_ff <= S_SHIFT_DN;
               end
            end
            // Open a slot at the insert position, one move a cycle.
            S_SHIFT_UP: begin
               if (i_ff > p_ff) begin
                  st_mem[ri] <= st_mem[IW'(i_ff - 1'b1)];
                  ln_mem[ri] <= ln_mem[IW'(i_ff - 1'b1)];
                  ct_mem[ri] <= ct_mem[IW'(i_ff - 1'b1)];
                  i_ff <= i_ff - 1'b1;
               end else begin
                  st_mem[ri] <= a_ff;
                  ln_mem[ri] <= nlen_ff;
                  ct_mem[ri] <= cnt_ff;
                  n_ff <= n_ff + 1'b1;
                  state_ff <= S_FINISH;
               end
            end
            // Close k_ff slots starting at p_ff, one move a cycle.
            S_SHIFT_DN: begin
               if ((p_ff + k_ff) < n_ff) begin
                  st_mem[p_ff[IW-1:0]] <= st_mem[IW'(p_ff + k_ff)];
                  ln_mem[p_ff[IW-1:0]] <= ln_mem[IW'(p_ff + k_ff)];
                  ct_mem[p_ff[IW-1:0]] <= ct_mem[IW'(p_ff + k_ff)];
                  p_ff <= p_ff + 1'b1;
               end else begin
                  n_ff <= n_ff - k_ff;
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

### sim/range_refcount_table_checker.sv
// Checker for the range reference-count table: predicts each result and compares it.
`timescale 1ns / 1ps
module range_refcount_table_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  rrt_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  rrt_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending,
   output int               beats_checked
);
   localparam int NENT = rrt_pkg::TABLE_ENTRIES_DEF;
   localparam logic [15:0] CNT_MAX = 16'hFFFF;

   // shadow copy of the tracked ranges
   logic [31:0] slot_start, slot_len;
   logic [15:0] slot_cnt;
   logic [31:0] ent_start [NENT];
   logic [31:0] ent_len [NENT];
   logic [15:0] ent_cnt [NENT];
   bit          ent_used [NENT];

   rrt_pkg::rsp_type expected_rsp_q[$];

   function automatic bit covers(logic [31:0] s, logic [31:0] l, logic [31:0] a);
      return a >= s && (a - s) < l;
   endfunction

   function automatic logic [15:0] cnt_add(logic [15:0] x, logic [15:0] y);
      logic [16:0] r;
      r = {1'b0, x} + {1'b0, y};
      return r > {1'b0, CNT_MAX} ? CNT_MAX : r[15:0];
   endfunction

   function automatic int fill_level();
      int n;
      n = 0;
      while (n < NENT && ent_used[n]) n++;
      return n;
   endfunction

   function automatic int lower_entry(int n, logic [31:0] a);
      int p;
      p = -1;
      for (int i = 0; i < n; i++) if (ent_start[i] <= a) p = i;
      return p;
   endfunction

   // close a gap of k entries starting at index at
   task automatic squeeze(int n, int at, int k);
      for (int i = at; i + k < n; i++) begin
         ent_start[i] = ent_start[i+k];
         ent_len[i]   = ent_len[i+k];
         ent_cnt[i]   = ent_cnt[i+k];
      end
      for (int i = n - k; i < n; i++) begin
         ent_used[i] = 0; ent_start[i] = '0; ent_len[i] = '0; ent_cnt[i] = '0;
      end
   endtask

   // add a new range, merging followers that start inside it
   task automatic place_range(int n, logic [31:0] a, logic [31:0] l, output bit ok);
      int p, k;
      logic [15:0] cnt;
      logic [32:0] off;
      logic [31:0] nl;
      p = 0; k = 0; cnt = 16'd1; nl = l;
      while (p < n && ent_start[p] < a) p++;
      while (p + k < n) begin
         off = {1'b0, ent_start[p+k] - a};
         if (!(off == '0 || off < {1'b0, l})) break;
         cnt = cnt_add(cnt, ent_cnt[p+k]);
         off = off + {1'b0, ent_len[p+k]};
         if (off[32]) off = 33'h0_FFFF_FFFF;
         if (off[31:0] > nl) nl = off[31:0];
         k++;
      end
      ok = 1;
      if (k == 0) begin
         if (n >= NENT) begin
            ok = 0;
            return;
         end
         for (int i = n; i > p; i--) begin
            ent_start[i] = ent_start[i-1];
            ent_len[i]   = ent_len[i-1];
            ent_cnt[i]   = ent_cnt[i-1];
         end
         ent_used[n] = 1;
      end else if (k > 1) begin
         squeeze(n, p + 1, k - 1);
      end
      ent_start[p] = a; ent_len[p] = nl; ent_cnt[p] = cnt;
   endtask

   task automatic predict_table(rrt_pkg::req_type r, output rrt_pkg::rsp_type o);
      int n, p;
      bit ok, slot_busy;
      n = fill_level();
      slot_busy = slot_cnt != '0;
      o = '0;
      if (r.func == rrt_pkg::FUNC_ENABLE) begin
         if (slot_busy && covers(slot_start, slot_len, r.address)) begin
            slot_cnt = cnt_add(slot_cnt, 16'd1);
         end else if (slot_busy || n > 0) begin
            p = lower_entry(n, r.address);
            if (p >= 0 && covers(ent_start[p], ent_len[p], r.address)) begin
               ent_cnt[p] = cnt_add(ent_cnt[p], 16'd1);
               if (ent_len[p] < r.length) ent_len[p] = r.length;
            end else begin
               place_range(n, r.address, r.length, ok);
               o.table_full = !ok;
            end
         end else begin
            slot_start = r.address; slot_len = r.length; slot_cnt = 16'd1;
         end
      end else begin
         if (slot_busy && covers(slot_start, slot_len, r.address)) begin
            slot_cnt = slot_cnt - 16'd1;
            if (slot_cnt == '0) begin
               slot_start = '0; slot_len = '0;
            end
         end else begin
            p = lower_entry(n, r.address);
            if (p >= 0 && covers(ent_start[p], ent_len[p], r.address)) begin
               ent_cnt[p] = ent_cnt[p] - 16'd1;
               if (ent_cnt[p] == '0) squeeze(n, p, 1);
            end else begin
               o.miss_error = 1;
            end
         end
      end
      o.active = slot_cnt != '0 || fill_level() > 0;
   endtask

   assign pending = expected_rsp_q.size();

   // predict on each request beat, compare on each result beat
   always @(posedge clock) begin
      rrt_pkg::rsp_type e;
      int errs;
      errs = 0;
      if (reset) begin
         slot_start = '0; slot_len = '0; slot_cnt = '0;
         for (int i = 0; i < NENT; i++) begin
            ent_used[i] = 0; ent_start[i] = '0; ent_len[i] = '0; ent_cnt[i] = '0;
         end
         expected_rsp_q.delete();
         fail_count <= 0;
         beats_checked <= 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_table(req_data, e);
            expected_rsp_q.push_back(e);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               $error("result beat with no expectation: %b", rsp_data);
               errs++;
            end else begin
               e = expected_rsp_q.pop_front();
               beats_checked <= beats_checked + 1;
               if (e.active !== rsp_data.active) begin
                  $error("active: expected %b, got %b", e.active, rsp_data.active);
                  errs++;
               end
               if (e.miss_error !== rsp_data.miss_error) begin
                  $error("miss_error: expected %b, got %b", e.miss_error,
                         rsp_data.miss_error);
                  errs++;
               end
               if (e.table_full !== rsp_data.table_full) begin
                  $error("table_full: expected %b, got %b", e.table_full,
                         rsp_data.table_full);
                  errs++;
               end
            end
         end
         if (errs != 0) fail_count <= fail_count + errs;
      end
   end
endmodule

### sim/range_refcount_table_top_test.sv
// Testbench top for the range reference-count table: stimulus and verdict.
`timescale 1ns / 1ps
module range_refcount_table_top_test;
   localparam int  RANDOM_ITEMS = 530;
   localparam longint CYCLE_LIMIT = 400000;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_ready;
   rrt_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 0;
   rrt_pkg::rsp_type rsp_data;
   int      fail_count, pending, beats_checked;
   bit      hold_off = 0;
   bit      stim_done = 0;
   longint  cycle_count = 0;
   int      enables = 0, disables = 0;
   logic [31:0] base_addr [8];

   range_refcount_table_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   range_refcount_table_checker chk (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending(pending), .beats_checked(beats_checked)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // send one beat, after a random gap unless gap is 0; hold until accepted
   task automatic send_beat(logic f, logic [31:0] a, logic [31:0] l, bit gap = 1);
      int w;
      w = gap ? $urandom_range(0, 5) : 0;
      if (w > 0) begin
         req_valid <= 0;
         repeat (w) @(negedge clock);
      end
      req_data  <= '{func: f, address: a, length: l};
      req_valid <= 1;
      if (f == rrt_pkg::FUNC_ENABLE) enables++; else disables++;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // receiver: random stalls per beat, plus a long hold-off on request
   initial begin
      int w;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_ready <= 0;
            repeat (300) @(negedge clock);
            hold_off = 0;
         end
         w = $urandom_range(0, 5);
         if (w > 0 && $urandom_range(0, 3) != 0) begin
            rsp_ready <= 0;
            repeat (w) @(negedge clock);
         end
         rsp_ready <= 1;
         @(posedge clock);
         while (!(rsp_valid && rsp_ready)) @(posedge clock);
         @(negedge clock);
      end
   end

   function automatic logic [31:0] pick_len();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom;
         default: return $urandom_range(1, 64);
      endcase
   endfunction

   // stimulus
   initial begin
      logic [31:0] a;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: empty-miss, first slot, hits, merges, saturation edges
      send_beat(rrt_pkg::FUNC_DISABLE, 32'h0, 32'h0);
      send_beat(rrt_pkg::FUNC_ENABLE, 32'h1000, 32'h0);
      send_beat(rrt_pkg::FUNC_ENABLE, 32'h1000, 32'h10);
      send_beat(rrt_pkg::FUNC_DISABLE, 32'h1000, 32'h0);
      send_beat(rrt_pkg::FUNC_DISABLE, 32'h1000, 32'h0);
      send_beat(rrt_pkg::FUNC_ENABLE, 32'h100, 32'h10);
      send_beat(rrt_pkg::FUNC_ENABLE, 32'h200, 32'h10);
      send_beat(rrt_pkg::FUNC_ENABLE, 32'h204, 32'h40);
      send_beat(rrt_pkg::FUNC_ENABLE, 32'h300, 32'h8);
      send_beat(rrt_pkg::FUNC_ENABLE, 32'h180, 32'h200);
      send_beat(rrt_pkg::FUNC_ENABLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_beat(rrt_pkg::FUNC_ENABLE, 32'hFFFF_FF00, 32'hFFFF_FFFF);
      send_beat(rrt_pkg::FUNC_DISABLE, 32'hFFFF_FFFF, 32'hAAAA_5555);
      send_beat(rrt_pkg::FUNC_DISABLE, 32'h0500, 32'h5555_AAAA);
      send_beat(rrt_pkg::FUNC_DISABLE, 32'h0180, 32'h0);
      // fill the table to provoke the full flag
      for (int i = 0; i < 18; i++)
         send_beat(rrt_pkg::FUNC_ENABLE, 32'h10_0000 + i * 32'h100, 32'h4, 0);
      // drain to an idle block, then continue
      req_valid <= 0;
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      // random: mostly well-formed enable/disable around a few bases
      for (int i = 0; i < 8; i++) base_addr[i] = $urandom & 32'hFFFF_F000;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 150) hold_off = 1;
         if (i == 300) begin
            req_valid <= 0;
            while (pending != 0) @(negedge clock);
         end
         if ($urandom_range(0, 9) == 0) a = $urandom;
         else a = base_addr[$urandom_range(0, 7)] + $urandom_range(0, 255);
         send_beat($urandom_range(0, 99) < 55 ? rrt_pkg::FUNC_ENABLE : rrt_pkg::FUNC_DISABLE,
                   a, pick_len());
      end
      req_valid <= 0;
      while (pending != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      $display("covered %0d enable and %0d disable beats, %0d results checked",
               enables, disables, beats_checked);
      $display("including table full, merges, misses and a long result stall");
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

### sim.f
hw/rtl/rrt_pkg.sv
hw/rtl/rrt_table.sv
hw/rtl/range_refcount_table_top.sv
sim/range_refcount_table_checker.sv
sim/range_refcount_table_top_test.sv
